// File: rtl/ordered_action_set_table_unit_assert.svh
// Assertion helpers shared by the checker.
`ifndef ORDERED_ACTION_SET_TABLE_UNIT_ASSERT_SVH
`define ORDERED_ACTION_SET_TABLE_UNIT_ASSERT_SVH

// Checked only out of reset.
`define OAST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define OAST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/oast_pkg.sv
package oast_pkg;

    localparam int SET_ENTRIES = 16;
    localparam int IDX_W       = $clog2(SET_ENTRIES);
    localparam int CNT_W       = $clog2(SET_ENTRIES + 1);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_CLEARED  = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [15:0] TYPE_OUTPUT       = 16'd0;
    localparam logic [15:0] TYPE_COPY_TTL_OUT = 16'd11;
    localparam logic [15:0] TYPE_COPY_TTL_IN  = 16'd12;
    localparam logic [15:0] TYPE_SET_MPLS_TTL = 16'd15;
    localparam logic [15:0] TYPE_DEC_MPLS_TTL = 16'd16;
    localparam logic [15:0] TYPE_PUSH_VLAN    = 16'd17;
    localparam logic [15:0] TYPE_POP_VLAN     = 16'd18;
    localparam logic [15:0] TYPE_PUSH_MPLS    = 16'd19;
    localparam logic [15:0] TYPE_POP_MPLS     = 16'd20;
    localparam logic [15:0] TYPE_SET_QUEUE    = 16'd21;
    localparam logic [15:0] TYPE_GROUP        = 16'd22;
    localparam logic [15:0] TYPE_SET_NW_TTL   = 16'd23;
    localparam logic [15:0] TYPE_DEC_NW_TTL   = 16'd24;
    localparam logic [15:0] TYPE_SET_FIELD    = 16'd25;
    localparam logic [15:0] TYPE_PUSH_PBB     = 16'd26;
    localparam logic [15:0] TYPE_POP_PBB      = 16'd27;
    localparam logic [15:0] TYPE_EXPERIMENTER = 16'hFFFF;

    typedef logic [6:0] t_prec;

    localparam t_prec PREC_COPY_IN  = 7'd10;
    localparam t_prec PREC_POP      = 7'd20;
    localparam t_prec PREC_PUSH     = 7'd30;
    localparam t_prec PREC_COPY_OUT = 7'd40;
    localparam t_prec PREC_DEC      = 7'd50;
    localparam t_prec PREC_SET      = 7'd60;
    localparam t_prec PREC_QUEUE    = 7'd70;
    localparam t_prec PREC_EXPER    = 7'd75;
    localparam t_prec PREC_OTHER    = 7'd79;
    localparam t_prec PREC_GROUP    = 7'd80;
    localparam t_prec PREC_OUTPUT   = 7'd90;

    typedef struct packed {
        logic [15:0] typ;
        logic [31:0] header;
        logic [15:0] handle;
    } t_entry;

    typedef struct packed {
        logic             clear;
        logic             replace;
        logic             insert;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_store_op;

    function automatic t_prec f_precedence(input logic [15:0] t);
        t_prec p;
        case (t)
            TYPE_COPY_TTL_IN:                                 p = PREC_COPY_IN;
            TYPE_POP_VLAN, TYPE_POP_MPLS, TYPE_POP_PBB:       p = PREC_POP;
            TYPE_PUSH_VLAN, TYPE_PUSH_MPLS, TYPE_PUSH_PBB:    p = PREC_PUSH;
            TYPE_COPY_TTL_OUT:                                p = PREC_COPY_OUT;
            TYPE_DEC_MPLS_TTL, TYPE_DEC_NW_TTL:               p = PREC_DEC;
            TYPE_SET_MPLS_TTL, TYPE_SET_NW_TTL, TYPE_SET_FIELD: p = PREC_SET;
            TYPE_SET_QUEUE:                                   p = PREC_QUEUE;
            TYPE_EXPERIMENTER:                                p = PREC_EXPER;
            TYPE_GROUP:                                       p = PREC_GROUP;
            TYPE_OUTPUT:                                      p = PREC_OUTPUT;
            default:                                          p = PREC_OTHER;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/ordered_action_set_table_unit.sv
// Clear and empty execute answer straight from idle; unused commands give no result. A write
// keeps busy high while the compare unit steps over the stored entries (at most count).
// Execute emits one entry per cycle, count entries in all.
// A new start is taken while the last result is shown; results come on o_valid for one
// cycle each and cannot be stalled.
// Reset (i_rst_n low, synchronous) empties the set and returns the sequencer to idle.
module ordered_action_set_table_unit
    import oast_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_action_type,
    input  logic [31:0] i_field_header,
    input  logic [15:0] i_action_handle,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_type,
    output logic [31:0] o_out_header,
    output logic [15:0] o_out_handle,
    output logic        o_last
);

    t_store_op        op;
    t_entry           rd_entry;
    logic [IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0] count;

    oast_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_rd_idx   (rd_idx),
        .o_rd_entry (rd_entry),
        .o_count    (count)
    );

    oast_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_cmd           (i_cmd),
        .i_action_type   (i_action_type),
        .i_field_header  (i_field_header),
        .i_action_handle (i_action_handle),
        .o_busy          (busy),
        .i_count         (count),
        .i_rd_entry      (rd_entry),
        .o_rd_idx        (rd_idx),
        .o_op            (op),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_type      (o_out_type),
        .o_out_header    (o_out_header),
        .o_out_handle    (o_out_handle),
        .o_last          (o_last)
    );

endmodule

// File: rtl/oast_store.sv
module oast_store
    import oast_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_op        i_op,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_entry,
    output logic [CNT_W-1:0] o_count
);

    t_entry           r_ent [SET_ENTRIES];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_rd_entry = r_ent[i_rd_idx];
    assign o_count    = r_count;

    always_comb begin
        n_count = r_count;
        if (i_op.clear) begin
            n_count = '0;
        end else if (i_op.insert) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Insert opens a slot at idx by moving every later entry up by one.
    for (genvar gi = 0; gi < SET_ENTRIES; gi++) begin : g_ent
        always_ff @(posedge i_clk) begin
            if (i_op.replace && i_op.idx == IDX_W'(gi)) begin
                r_ent[gi].header <= i_op.entry.header;
                r_ent[gi].handle <= i_op.entry.handle;
            end else if (i_op.insert && i_op.idx == IDX_W'(gi)) begin
                r_ent[gi] <= i_op.entry;
            end else if (i_op.insert && IDX_W'(gi) > i_op.idx) begin
                r_ent[gi] <= r_ent[(gi > 0) ? gi - 1 : 0];
            end
        end
    end

endmodule

// File: rtl/oast_ctrl.sv
module oast_ctrl
    import oast_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_cmd,
    input  logic [15:0]      i_action_type,
    input  logic [31:0]      i_field_header,
    input  logic [15:0]      i_action_handle,
    output logic             o_busy,
    input  logic [CNT_W-1:0] i_count,
    input  t_entry           i_rd_entry,
    output logic [IDX_W-1:0] o_rd_idx,
    output t_store_op        o_op,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [15:0]      o_out_type,
    output logic [31:0]      o_out_header,
    output logic [15:0]      o_out_handle,
    output logic             o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [15:0]      r_t, n_t;
    logic [31:0]      r_h, n_h;
    logic [15:0]      r_hd, n_hd;
    t_prec            r_prec, n_prec;

    logic             r_valid, n_valid;
    logic [2:0]       r_status, n_status;
    t_entry           r_res, n_res;
    logic             r_last, n_last;

    logic             type_eq;
    logic             hdr_ok;
    logic             goes_before;
    logic             full;
    logic             at_end;
    logic             last_emit;

    assign o_rd_idx = r_idx[IDX_W-1:0];
    assign o_busy   = (r_state != S_IDLE);

    // Compare unit: one stored entry against the pending write per cycle.
    assign type_eq     = (i_rd_entry.typ == r_t);
    assign hdr_ok      = (r_t != TYPE_SET_FIELD) || (i_rd_entry.header == r_h);
    assign goes_before = !type_eq && (r_prec < f_precedence(i_rd_entry.typ));
    assign full        = (i_count == CNT_W'(SET_ENTRIES));
    assign at_end      = (r_idx == i_count);
    assign last_emit   = ((r_idx + 1'b1) == i_count);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_t       = r_t;
        n_h       = r_h;
        n_hd      = r_hd;
        n_prec    = r_prec;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_res     = r_res;
        n_last    = r_last;
        o_op      = '0;
        o_op.idx  = r_idx[IDX_W-1:0];
        o_op.entry = '{typ: r_t, header: r_h, handle: r_hd};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_t    = i_action_type;
                    n_h    = i_field_header;
                    n_hd   = i_action_handle;
                    n_prec = f_precedence(i_action_type);
                    n_idx  = '0;
                    case (i_cmd)
                        CMD_WRITE: begin
                            n_state = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            o_op.clear = 1'b1;
                            n_valid    = 1'b1;
                            n_status   = ST_CLEARED;
                            n_res      = '0;
                            n_last     = 1'b1;
                        end
                        CMD_EXEC: begin
                            if (i_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                                n_res    = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                n_res  = '0;
                n_last = 1'b1;
                if (at_end || (!(type_eq && hdr_ok) && goes_before)) begin
                    // Slot found: append or open a gap, unless no room is left.
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_op.insert = 1'b1;
                        n_status    = ST_INSERTED;
                    end
                end else if (type_eq && hdr_ok) begin
                    o_op.replace = 1'b1;
                    n_valid      = 1'b1;
                    n_status     = ST_REPLACED;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                n_valid  = 1'b1;
                n_status = ST_EMIT;
                n_res    = i_rd_entry;
                n_last   = last_emit;
                if (last_emit) begin
                    o_op.clear = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_h      <= n_h;
        r_hd     <= n_hd;
        r_prec   <= n_prec;
        r_status <= n_status;
        r_res    <= n_res;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_out_type   = r_res.typ;
    assign o_out_header = r_res.header;
    assign o_out_handle = r_res.handle;
    assign o_last       = r_last;

endmodule

// File: rtl/oast_checker.sv
`include "ordered_action_set_table_unit_assert.svh"

module oast_checker
    import oast_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_cmd,
    input logic       o_valid,
    input logic [2:0] o_status,
    input logic       o_last
);

    `OAST_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid && !busy, "output or busy after reset")

    `OAST_ASSERT(a_clear_result, start && !busy && i_cmd == CMD_CLEAR |=> o_valid && o_status == ST_CLEARED && o_last, "clear gave no single cleared result")

    `OAST_ASSERT(a_single_last, o_valid && o_status != ST_EMIT |-> o_last, "non-emit result without last")

    `OAST_ASSERT(a_last_frees, o_valid && o_last |-> !busy, "still busy after final transfer")

endmodule

bind ordered_action_set_table_unit oast_checker u_oast_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_last   (o_last)
);
